// File: rtl/core/deque_with_search_assert.svh
// Assertion macros used by the deque checker file.
`ifndef DEQUE_WITH_SEARCH_ASSERT_SVH
`define DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DWS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dws_pkg.sv
// Types, command and status codes shared by the deque modules.
`timescale 1ns / 1ps
`default_nettype none

package dws_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;   // holds 0..DEPTH

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] out_value;
        logic [CNT_W-1:0]         position;
        logic [CNT_W-1:0]         occupancy;
    } out_item_t;

    // Per-cycle operation strobes broadcast to every cell.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic search;
    } dws_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/dws_cell.sv
// One deque slot: holds a word and its occupied mark, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module dws_cell
    import dws_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dws_ctrl_t ctrl,
    input  wire word_t     key,
    input  wire word_t     left_data,
    input  wire logic      left_valid,
    input  wire word_t     right_data,
    input  wire logic      right_valid,
    output word_t          data,
    output logic           valid,
    output logic           match,
    output word_t          tail_word
);

    word_t data_reg, data_next;
    logic  valid_reg, valid_next;
    logic  match_reg, match_next;
    logic  is_back_slot;
    logic  is_tail;

    // first free slot after the occupied run
    assign is_back_slot = !valid_reg && left_valid;
    assign is_tail      = valid_reg && !right_valid;

    always_comb begin
        priority if (ctrl.push_front) begin
            valid_next = left_valid;
            data_next  = left_data;
        end else if (ctrl.pop_front) begin
            valid_next = right_valid;
            data_next  = right_data;
        end else if (ctrl.push_back && is_back_slot) begin
            valid_next = 1'b1;
            data_next  = key;
        end else if (ctrl.pop_back && is_tail) begin
            valid_next = 1'b0;
            data_next  = data_reg;
        end else begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
        match_next = ctrl.search ? (valid_reg && (data_reg == key)) : match_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign match     = match_reg;
    assign tail_word = is_tail ? data_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/deque_with_search.sv
// Top level: bounded double-ended queue of 32-bit words with first-match search.
// Push and pop results appear in the cycle after the item is accepted; search
//   results wait for the match flags registered in the cells, then are
//   priority-encoded into a position and registered once the output is free.
// Throughput: one push or pop per cycle while m_ready is high; no item is taken
//   during search. Reset (synchronous, active low) empties the queue and output.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_search
    import dws_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    localparam logic [0:0] ST_IDLE   = 1'b0;
    localparam logic [0:0] ST_SEARCH = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    dws_ctrl_t        ctrl;
    word_t            cell_data  [DEPTH];
    logic             cell_valid [DEPTH];
    logic             cell_match [DEPTH];
    word_t            cell_tail  [DEPTH];
    word_t            key;
    word_t            tail_or;
    logic             found;
    logic [CNT_W-1:0] found_pos;
    logic             accept;
    logic             slot_free;
    logic             full;
    logic             empty;

    assign key       = word_t'(s_item.value);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);

    always_comb begin
        ctrl.push_front = accept && (s_item.cmd == CMD_PUSH_FRONT) && !full;
        ctrl.push_back  = accept && (s_item.cmd == CMD_PUSH_BACK) && !full;
        ctrl.pop_front  = accept && (s_item.cmd == CMD_POP_FRONT) && !empty;
        ctrl.pop_back   = accept && (s_item.cmd == CMD_POP_BACK) && !empty;
        ctrl.search     = accept && (s_item.cmd == CMD_SEARCH);
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t left_data, right_data;
        logic  left_valid, right_valid;

        if (i == 0) begin : g_first
            assign left_data  = key;
            assign left_valid = 1'b1;
        end else begin : g_inner_l
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_r
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        dws_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (key),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .match       (cell_match[i]),
            .tail_word   (cell_tail[i])
        );
    end

    // only the back cell contributes a nonzero word
    always_comb begin
        tail_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_or = tail_or | cell_tail[i];
        end
    end

    // first match from the front wins
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                found     = 1'b1;
                found_pos = CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.push_front || ctrl.push_back) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (ctrl.pop_front || ctrl.pop_back) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_item_next.status    = STAT_OK;
                    m_item_next.out_value = '0;
                    m_item_next.position  = '0;
                    m_item_next.occupancy = cnt_next;
                    unique case (s_item.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (full) begin
                                m_item_next.status = STAT_FULL;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                m_item_next.status = STAT_EMPTY;
                            end else begin
                                m_item_next.out_value = cell_data[0];
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                m_item_next.status = STAT_EMPTY;
                            end else begin
                                m_item_next.out_value = tail_or;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (s_item.cmd == CMD_SEARCH) begin
                        state_next = ST_SEARCH;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (slot_free) begin
                    m_item_next.status    = found ? STAT_OK : STAT_NOT_FOUND;
                    m_item_next.out_value = '0;
                    m_item_next.position  = found_pos;
                    m_item_next.occupancy = cnt_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// File: rtl/core/dws_checker.sv
// Port-level checks on the deque result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "deque_with_search_assert.svh"

module dws_checker
    import dws_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    `DWS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result item changed while stalled")

    `DWS_ASSERT_NOW(a_occ_bound, aclk, aresetn, m_valid, m_item.occupancy <= CNT_W'(DEPTH), "occupancy above depth")

    `DWS_ASSERT_NOW(a_empty_pop, aclk, aresetn, m_valid && (m_item.status == STAT_EMPTY), (m_item.out_value == '0) && (m_item.occupancy == '0), "failed pop with data or entries")

    `DWS_ASSERT_NOW(a_full_push, aclk, aresetn, m_valid && (m_item.status == STAT_FULL), m_item.occupancy == CNT_W'(DEPTH), "full status below depth")

    `DWS_ASSERT_NOW(a_pos_range, aclk, aresetn, m_valid, (m_item.position <= m_item.occupancy) && ((m_item.status != STAT_NOT_FOUND) || (m_item.position == '0)), "search position out of range")

endmodule

bind deque_with_search dws_checker u_dws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for deque_with_search: directed corner cases plus random queue traffic.
`timescale 1ns / 1ps

module tb;
    import dws_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_SEARCH + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // Ring-buffer model of the deque; predicts one result per accepted item.
    class deque_tracker;
        word_t     ring[DEPTH];
        int        head;
        int        fill;
        out_item_t pending_results[$];
        int        errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function word_t entry_at(int offset);
            return ring[(head + offset) % DEPTH];
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            r = '0;
            case (it.cmd)
                CMD_PUSH_FRONT: begin
                    if (fill == DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = it.value;
                        fill++;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (fill == DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        ring[(head + fill) % DEPTH] = it.value;
                        fill++;
                    end
                end
                CMD_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.out_value = ring[head];
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                CMD_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.out_value = entry_at(fill - 1);
                        fill--;
                    end
                end
                CMD_SEARCH: begin
                    r.status = STAT_NOT_FOUND;
                    for (int i = 0; i < fill; i++) begin
                        if (entry_at(i) == it.value) begin
                            r.status   = STAT_OK;
                            r.position = CNT_W'(i + 1);
                            break;
                        end
                    end
                end
                default: ;  // spare codes leave the store alone
            endcase
            r.occupancy = CNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.out_value !== want.out_value) begin
                $display("%0t: out_value expected %h actual %h", $time,
                         want.out_value, got.out_value);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position expected %0d actual %0d", $time,
                         want.position, got.position);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d", $time,
                         want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    logic      hold_req;
    int        idle_count;

    deque_tracker tracker;

    deque_with_search uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offers one item at the falling edge and holds it until accepted.
    task automatic send(input logic [CMD_W-1:0] cmd, input word_t value);
        @(negedge aclk);
        s_valid = 1'b1;
        s_item  = {cmd, value};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause(input int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        s_item  = {3'($urandom), 32'($urandom)};
        repeat (cycles - 1) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
    endtask

    // mode: 0 leans to pushes, 1 leans to pops, 2 balanced, 3 search heavy
    function automatic void pick_item(input int mode, output logic [CMD_W-1:0] cmd,
                                      output word_t value);
        int roll;
        int push_pct;
        int pop_pct;
        case (mode)
            0:       begin push_pct = 70; pop_pct = 15; end
            1:       begin push_pct = 15; pop_pct = 70; end
            2:       begin push_pct = 40; pop_pct = 40; end
            default: begin push_pct = 25; pop_pct = 25; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 4)
            cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else if (roll < 4 + push_pct)
            cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (roll < 4 + push_pct + pop_pct)
            cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        else
            cmd = CMD_SEARCH;
        // small pool makes duplicates, so first-match order matters
        case ($urandom_range(0, 3))
            0:       value = $urandom_range(0, 7);
            1:       value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: value = $urandom;
        endcase
        if (cmd == CMD_SEARCH && tracker.fill > 0 && $urandom_range(0, 2) != 0)
            value = tracker.entry_at($urandom_range(0, tracker.fill - 1));
    endfunction

    // Result side: stall pattern of its own, plus one long hold-off on request.
    initial begin : receiver
        int rx_mode;
        int span;
        m_ready = 1'b0;
        span    = 0;
        rx_mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    span    = $urandom_range(8, 64);
                end
                span--;
                case (rx_mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_item(s_item);
            if (m_valid && m_ready)
                tracker.check_result(m_item);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("deque_with_search verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0] cmd;
        word_t            value;
        int               sent;
        int               burst;
        int               mode;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_item     = '0;
        hold_req   = 1'b0;
        idle_count = 0;
        tracker    = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty store: search, both pops, spare codes
        send(CMD_SEARCH, '0);
        send(CMD_POP_FRONT, '0);
        send(CMD_POP_BACK, '0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send(CMD_W'(c), '1);
        send(CMD_PUSH_FRONT, 32'h7fff_ffff);
        send(CMD_PUSH_BACK, 32'h8000_0000);
        send(CMD_PUSH_FRONT, 32'hffff_ffff);
        send(CMD_PUSH_BACK, '0);
        send(CMD_SEARCH, 32'h8000_0000);
        send(CMD_SEARCH, 32'h1234_5678);
        send(CMD_POP_FRONT, '0);
        send(CMD_POP_BACK, '0);
        // fill from both ends; the last back push lands at the far end
        for (int i = 0; i < DEPTH - 2; i++)
            send((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, word_t'(i));
        send(CMD_PUSH_FRONT, 32'hdead_beef);
        send(CMD_PUSH_BACK, 32'hdead_beef);
        send(CMD_SPARE_HI, '0);
        send(CMD_SEARCH, word_t'(DEPTH - 3));

        sent = 0;
        mode = 1;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                if (tracker.fill == DEPTH && $urandom_range(0, 1))
                    mode = 1;
                else if (tracker.fill == 0 && $urandom_range(0, 1))
                    mode = 0;
                pick_item(mode, cmd, value);
                send(cmd, value);
                sent++;
                if (sent == 250)
                    hold_req = 1'b1;
                if (sent == 500)
                    wait_drained();
            end
            if ($urandom_range(0, 3) == 0)
                mode = $urandom_range(0, 3);
            if ($urandom_range(0, 4) != 0)
                pause($urandom_range(1, 10));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0)
            $display("deque_with_search verification clean");
        else
            $display("deque_with_search verification failed");
        $finish;
    end

endmodule
